// File: rtl/srpg_pkg.sv
// Shared types and constants for the stepper ramp pulse generator.
package srpg_pkg;

    localparam int STEP_W    = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_STEP = 8'd3;

    // Reset values: whole microseconds for periods, thousandths for steps.
    localparam longint unsigned MIN_PERIOD_US    = 64'd18;
    localparam longint unsigned MAX_PERIOD_US    = 64'd38;
    localparam longint unsigned ACCEL_STEP_MILLI = 64'd8;
    localparam longint unsigned DECEL_STEP_MILLI = 64'd20;
    localparam longint unsigned STEP_SAT         = 64'd65535;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } phase_t;

    typedef struct packed {
        logic   step_pulse;
        phase_t phase;
        logic   finished;
    } motion_res_t;

endpackage

// File: rtl/srpg_if.sv
// Request channel interfaces: tick input, pulse output and register write.
interface srpg_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic limit_a;
    logic limit_b;

    modport source (output valid, output start_req, output limit_a, output limit_b,
                    input ready);
    modport sink   (input valid, input start_req, input limit_a, input limit_b,
                    output ready);
endinterface

interface srpg_out_if;
    logic       valid;
    logic       ready;
    logic       step_pulse;
    logic [1:0] phase;
    logic       finished;

    modport source (output valid, output step_pulse, output phase, output finished,
                    input ready);
    modport sink   (input valid, input step_pulse, input phase, input finished,
                    output ready);
endinterface

interface srpg_cfg_if
    import srpg_pkg::*;
#(
    parameter int DATA_W = 24
);
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/stepper_ramp_pulse_generator_core.sv
// Top level of the stepper ramp pulse generator: channels, registers, result stage.
//
// Each input request is one microsecond tick; each tick yields one output request
// with the step line level, the motion phase and a finished flag. One tick is
// taken per clock cycle while the output is not stalled: a tick is captured in
// the input register, evaluated in one pass through the motion logic and held in
// the output register, so a new tick is accepted while the previous result waits.
// Registers 0..3 (min_period, max_period, accel_step, decel_step) are written
// through the cfg channel; the user must write them only while no tick is in
// flight, which the block itself does not enforce. Writes take effect at once,
// also during a move; writes to other indexes are dropped. Periods are unsigned
// fixed point with PERIOD_INT_BITS integer and PERIOD_FRAC_BITS fraction bits.
module stepper_ramp_pulse_generator_core
    import srpg_pkg::*;
#(
    parameter int PERIOD_INT_BITS  = 8,
    parameter int PERIOD_FRAC_BITS = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    srpg_in_if.sink    step_in,
    srpg_out_if.source step_out,
    srpg_cfg_if.sink   cfg
);

    localparam int PB = PERIOD_INT_BITS + PERIOD_FRAC_BITS;

    localparam longint unsigned ONE_US     = 64'd1 << PERIOD_FRAC_BITS;
    localparam longint unsigned ACCEL_RAW  = (ACCEL_STEP_MILLI * ONE_US + 64'd500) / 64'd1000;
    localparam longint unsigned DECEL_RAW  = (DECEL_STEP_MILLI * ONE_US + 64'd500) / 64'd1000;
    localparam longint unsigned ACCEL_SAT  = (ACCEL_RAW > STEP_SAT) ? STEP_SAT : ACCEL_RAW;
    localparam longint unsigned DECEL_SAT  = (DECEL_RAW > STEP_SAT) ? STEP_SAT : DECEL_RAW;

    localparam logic [PB-1:0]     MIN_PERIOD_RST = PB'(MIN_PERIOD_US << PERIOD_FRAC_BITS);
    localparam logic [PB-1:0]     MAX_PERIOD_RST = PB'(MAX_PERIOD_US << PERIOD_FRAC_BITS);
    localparam logic [STEP_W-1:0] ACCEL_RST      = STEP_W'(ACCEL_SAT);
    localparam logic [STEP_W-1:0] DECEL_RST      = STEP_W'(DECEL_SAT);

    logic [PB-1:0]     min_period_reg;
    logic [PB-1:0]     max_period_reg;
    logic [STEP_W-1:0] accel_step_reg;
    logic [STEP_W-1:0] decel_step_reg;

    logic        in_valid_reg;
    logic        start_reg;
    logic        limit_reg;
    logic        out_valid_reg;
    motion_res_t out_reg;
    motion_res_t res;
    logic        advance;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= MIN_PERIOD_RST;
            max_period_reg <= MAX_PERIOD_RST;
            accel_step_reg <= ACCEL_RST;
            decel_step_reg <= DECEL_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MIN_PERIOD: min_period_reg <= cfg.data[PB-1:0];
                REG_MAX_PERIOD: max_period_reg <= cfg.data[PB-1:0];
                REG_ACCEL_STEP: accel_step_reg <= cfg.data[STEP_W-1:0];
                REG_DECEL_STEP: decel_step_reg <= cfg.data[STEP_W-1:0];
                default:        min_period_reg <= min_period_reg;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || step_out.ready);
    assign step_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (step_in.ready)
            in_valid_reg <= step_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step_in.ready && step_in.valid)
        begin
            start_reg <= step_in.start_req;
            limit_reg <= step_in.limit_a | step_in.limit_b;
        end
    end

    srpg_motion #(
        .PERIOD_INT_BITS  (PERIOD_INT_BITS),
        .PERIOD_FRAC_BITS (PERIOD_FRAC_BITS)
    ) u_motion (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .start_req  (start_reg),
        .limit      (limit_reg),
        .min_period (min_period_reg),
        .max_period (max_period_reg),
        .accel_step (accel_step_reg),
        .decel_step (decel_step_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (step_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign step_out.valid      = out_valid_reg;
    assign step_out.step_pulse = out_reg.step_pulse;
    assign step_out.phase      = out_reg.phase;
    assign step_out.finished   = out_reg.finished;

endmodule

// File: rtl/srpg_motion.sv
// Motion state machine: ramp period, half-period tick counter and pulse level.
module srpg_motion
    import srpg_pkg::*;
#(
    parameter int PERIOD_INT_BITS  = 8,
    parameter int PERIOD_FRAC_BITS = 16
)(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      advance,
    input  logic                                      start_req,
    input  logic                                      limit,
    input  logic [PERIOD_INT_BITS+PERIOD_FRAC_BITS-1:0] min_period,
    input  logic [PERIOD_INT_BITS+PERIOD_FRAC_BITS-1:0] max_period,
    input  logic [STEP_W-1:0]                         accel_step,
    input  logic [STEP_W-1:0]                         decel_step,
    output motion_res_t                               res
);

    localparam int PB = PERIOD_INT_BITS + PERIOD_FRAC_BITS;
    localparam int W  = ((PB > STEP_W) ? PB : STEP_W) + 1;
    localparam int IB = PERIOD_INT_BITS;

    phase_t          phase_reg, phase_next;
    logic [PB-1:0]   period_reg, period_next;
    logic [IB-1:0]   cnt_reg, cnt_next;
    logic            level_reg, level_next;
    logic            fin;

    logic            launch;
    logic            start_accel;
    phase_t          eff_phase;
    logic [PB-1:0]   eff_period;
    logic [IB-1:0]   eff_cnt;
    logic            eff_level;
    logic [IB-1:0]   int_part;
    logic [IB-1:0]   half_len;
    logic [IB-1:0]   cnt_inc;
    logic            half_done;
    logic [W-1:0]    per_x;
    logic [W-1:0]    acc_x;
    logic [W-1:0]    sub_x;
    logic [W-1:0]    sum_x;
    logic [PB-1:0]   sub_p;
    logic [PB-1:0]   sum_p;

    assign launch      = (phase_reg == PH_IDLE) && start_req;
    assign start_accel = max_period > min_period;

    always_comb
    begin
        if (phase_reg == PH_IDLE)
        begin
            eff_phase  = start_accel ? PH_ACCEL : PH_CRUISE;
            eff_period = start_accel ? max_period : min_period;
            eff_cnt    = '0;
            eff_level  = 1'b1;
        end
        else
        begin
            eff_phase  = phase_reg;
            eff_period = period_reg;
            eff_cnt    = cnt_reg;
            eff_level  = level_reg;
        end
    end

    assign int_part  = eff_period[PB-1:PERIOD_FRAC_BITS];
    assign half_len  = (int_part == '0) ? IB'(1) : int_part;
    assign cnt_inc   = eff_cnt + IB'(1);
    assign half_done = (cnt_inc == '0) || (cnt_inc >= half_len);

    assign per_x = W'(eff_period);
    assign acc_x = W'(accel_step);
    assign sub_x = (acc_x > per_x) ? '0 : (per_x - acc_x);
    assign sub_p = sub_x[PB-1:0];
    assign sum_x = per_x + W'(decel_step);
    assign sum_p = (sum_x[W-1:PB] != '0) ? {PB{1'b1}} : sum_x[PB-1:0];

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        period_next = period_reg;
        cnt_next    = cnt_reg;
        level_next  = level_reg;
        fin         = 1'b0;
        if ((phase_reg != PH_IDLE) || start_req)
        begin
            phase_next  = eff_phase;
            period_next = eff_period;
            level_next  = eff_level;
            cnt_next    = cnt_inc;
            if (half_done)
            begin
                cnt_next = '0;
                if (eff_level)
                begin
                    level_next = 1'b0;
                end
                else
                begin
                    level_next = 1'b1;
                    unique case (eff_phase)
                        PH_ACCEL:
                        begin
                            period_next = sub_p;
                            if (!(sub_p > min_period))
                            begin
                                phase_next  = PH_CRUISE;
                                period_next = min_period;
                            end
                        end
                        PH_CRUISE:
                        begin
                            if (limit)
                            begin
                                period_next = min_period;
                                if (min_period < max_period)
                                    phase_next = PH_DECEL;
                                else
                                    fin = 1'b1;
                            end
                        end
                        PH_DECEL:
                        begin
                            period_next = sum_p;
                            if (!(sum_p < max_period))
                                fin = 1'b1;
                        end
                        default:
                        begin
                            phase_next = eff_phase;
                        end
                    endcase
                    if (fin)
                    begin
                        phase_next = PH_IDLE;
                        level_next = 1'b0;
                    end
                end
            end
        end
    end

    // outputs
    always_comb
    begin
        res.finished = fin;
        if (phase_reg == PH_IDLE)
        begin
            res.step_pulse = launch;
            res.phase      = launch ? eff_phase : PH_IDLE;
        end
        else
        begin
            res.step_pulse = level_reg;
            res.phase      = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            period_reg <= '0;
            cnt_reg    <= '0;
            level_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            period_reg <= period_next;
            cnt_reg    <= cnt_next;
            level_reg  <= level_next;
        end
    end

`ifndef SYNTH
    logic [IB-1:0] reg_int_part;
    logic [IB-1:0] reg_half_len;

    assign reg_int_part = period_reg[PB-1:PERIOD_FRAC_BITS];
    assign reg_half_len = (reg_int_part == '0) ? IB'(1) : reg_int_part;

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (!level_reg && (cnt_reg == '0)))
        else $error("idle with pulse level or count left over");

    a_cnt_in_half: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (cnt_reg < reg_half_len))
        else $error("half-period counter beyond half length");

    a_fin_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.finished) |->
        (!res.step_pulse && ((res.phase == PH_CRUISE) || (res.phase == PH_DECEL))))
        else $error("finish outside a low half of cruise or decel");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.finished) |=> (phase_reg == PH_IDLE))
        else $error("move did not go idle after finish");
`endif

endmodule

// File: verif/tb_stepper_ramp_pulse_generator_core.sv
// Self-checking testbench for the stepper ramp pulse generator core.
`timescale 1ns / 1ps

module tb_stepper_ramp_pulse_generator_core;
    import srpg_pkg::*;

    localparam int INT_W  = 8;
    localparam int FRAC_W = 16;
    localparam int PER_W  = INT_W + FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_BATCH = 8;

    typedef struct packed {
        logic       start_req;
        logic [1:0] limits;
    } tick_t;

    logic clk = 1'b0;
    logic rst_n;

    srpg_in_if                    tick_bus ();
    srpg_out_if                   pulse_bus ();
    srpg_cfg_if #(.DATA_W(PER_W)) cfg_bus ();

    stepper_ramp_pulse_generator_core #(
        .PERIOD_INT_BITS  (INT_W),
        .PERIOD_FRAC_BITS (FRAC_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_in  (tick_bus),
        .step_out (pulse_bus),
        .cfg      (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // motion state and register shadow
    phase_t              m_phase;
    logic [PER_W-1:0]    m_period;
    logic [INT_W-1:0]    m_count;
    logic                m_level;
    logic [PER_W-1:0]    reg_min;
    logic [PER_W-1:0]    reg_max;
    logic [STEP_W-1:0]   reg_accel;
    logic [STEP_W-1:0]   reg_decel;

    tick_t       tick_q[$];
    motion_res_t awaited_outputs[$];
    bit          tick_offered = 1'b0;

    int mismatches   = 0;
    int ticks_queued = 0;
    int ticks_sent   = 0;
    int results_seen = 0;
    int moves_done   = 0;
    int configs_used = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;

    function automatic logic [STEP_W-1:0] rounded_step(input longint unsigned milli);
        longint unsigned v;
        v = (milli * (64'd1 << FRAC_W) + 64'd500) / 64'd1000;
        return (v > STEP_SAT) ? STEP_W'(STEP_SAT) : STEP_W'(v);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at result %0d: %s", results_seen, msg);
    endtask

    task automatic advance_motion(input logic start, input logic lim);
        motion_res_t      r;
        logic [INT_W-1:0] span;
        logic [PER_W:0]   wide;
        logic             done;
        r = '0;
        done = 1'b0;
        if (m_phase == PH_IDLE && !start) begin
            awaited_outputs.push_back(r);
            return;
        end
        if (m_phase == PH_IDLE) begin
            if (reg_max > reg_min) begin
                m_phase  = PH_ACCEL;
                m_period = reg_max;
            end else begin
                m_phase  = PH_CRUISE;
                m_period = reg_min;
            end
            m_level = 1'b1;
            m_count = '0;
        end
        r.step_pulse = m_level;
        r.phase      = m_phase;
        span = m_period[FRAC_W +: INT_W];
        if (span == 0)
            span = INT_W'(1);
        m_count = m_count + 1'b1;
        if (m_count == 0 || m_count >= span) begin
            m_count = '0;
            if (m_level) begin
                m_level = 1'b0;
            end else begin
                m_level = 1'b1;
                case (m_phase)
                    PH_ACCEL:
                    begin
                        m_period = (reg_accel > m_period) ? '0 : m_period - reg_accel;
                        if (!(m_period > reg_min)) begin
                            m_phase  = PH_CRUISE;
                            m_period = reg_min;
                        end
                    end
                    PH_CRUISE:
                    begin
                        if (lim) begin
                            m_period = reg_min;
                            if (reg_min < reg_max)
                                m_phase = PH_DECEL;
                            else
                                done = 1'b1;
                        end
                    end
                    default:
                    begin
                        wide = {1'b0, m_period} + reg_decel;
                        m_period = wide[PER_W] ? '1 : wide[PER_W-1:0];
                        if (!(m_period < reg_max))
                            done = 1'b1;
                    end
                endcase
                if (done) begin
                    m_phase = PH_IDLE;
                    m_level = 1'b0;
                end
            end
        end
        r.finished = done;
        awaited_outputs.push_back(r);
    endtask

    // driver: offers queued tick requests, holds each until taken
    always @(negedge clk)
    begin : tick_drive
        if (!rst_n) begin
            tick_bus.valid <= 1'b0;
        end else if (!tick_offered) begin
            if (tick_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                tick_bus.valid     <= 1'b1;
                tick_bus.start_req <= tick_q[0].start_req;
                tick_bus.limit_a   <= tick_q[0].limits[0];
                tick_bus.limit_b   <= tick_q[0].limits[1];
                tick_offered = 1'b1;
            end else begin
                tick_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : tick_take
        tick_t t;
        if (rst_n && tick_offered && tick_bus.valid && tick_bus.ready) begin
            t = tick_q.pop_front();
            advance_motion(t.start_req, |t.limits);
            ticks_sent++;
            tick_offered = 1'b0;
        end
    end

    always @(posedge clk)
    begin : hold_off_count
        if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    always @(negedge clk)
    begin : out_ready_drive
        pulse_bus.ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin : out_check
        motion_res_t want;
        if (rst_n && pulse_bus.valid && pulse_bus.ready) begin
            results_seen++;
            if (awaited_outputs.size() == 0) begin
                flag_mismatch("output request with nothing predicted");
            end else begin
                want = awaited_outputs.pop_front();
                if (pulse_bus.step_pulse !== want.step_pulse)
                    flag_mismatch($sformatf("step_pulse %b, predicted %b",
                                            pulse_bus.step_pulse, want.step_pulse));
                if (pulse_bus.phase !== want.phase)
                    flag_mismatch($sformatf("phase %0d, predicted %0d",
                                            pulse_bus.phase, want.phase));
                if (pulse_bus.finished !== want.finished)
                    flag_mismatch($sformatf("finished %b, predicted %b",
                                            pulse_bus.finished, want.finished));
                if (want.finished)
                    moves_done++;
            end
        end
    end

    task automatic queue_tick(input logic start, input logic [1:0] lim);
        tick_t t;
        t.start_req = start;
        t.limits    = lim;
        tick_q.push_back(t);
        ticks_queued++;
    endtask

    task automatic settle();
        while (tick_q.size() != 0 || tick_offered || awaited_outputs.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PER_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_MIN_PERIOD: reg_min   = val;
            REG_MAX_PERIOD: reg_max   = val;
            REG_ACCEL_STEP: reg_accel = val[STEP_W-1:0];
            REG_DECEL_STEP: reg_decel = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [PER_W-1:0] lo_p, input logic [PER_W-1:0] hi_p,
                                input logic [STEP_W-1:0] up, input logic [STEP_W-1:0] dn);
        settle();
        repeat (4) @(negedge clk);
        write_reg(REG_MIN_PERIOD, lo_p);
        write_reg(REG_MAX_PERIOD, hi_p);
        write_reg(REG_ACCEL_STEP, PER_W'(up));
        write_reg(REG_DECEL_STEP, PER_W'(dn));
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        configs_used++;
    endtask

    // keep a limit switch set until the current move has ended
    task automatic finish_move();
        settle();
        while (m_phase != PH_IDLE) begin
            repeat (DRAIN_BATCH) queue_tick(1'b0, 2'($urandom_range(1, 3)));
            settle();
        end
    endtask

    task automatic fill_moves(input int want);
        int         stop;
        int         n;
        logic [1:0] lim;
        stop = ticks_queued + want;
        while (ticks_queued < stop) begin
            if ($urandom_range(0, 4) != 0) begin
                n = $urandom_range(0, 3);
                repeat (n) queue_tick(1'b0, 2'($urandom));
                queue_tick(1'b1, 2'($urandom));
                n = $urandom_range(5, 120);
                repeat (n) begin
                    lim = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
                    queue_tick($urandom_range(0, 7) == 0, lim);
                end
                n = $urandom_range(1, 40);
                repeat (n) queue_tick(1'b0, 2'($urandom_range(1, 3)));
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) queue_tick(1'($urandom), 2'($urandom));
            end
        end
    endtask

    initial
    begin : stimulus
        int                tx_tbl[4];
        int                rx_tbl[4];
        int                k;
        int unsigned       sel;
        logic [PER_W-1:0]  lo;
        logic [PER_W-1:0]  hi;
        logic [STEP_W-1:0] up;
        logic [STEP_W-1:0] dn;

        tx_tbl = '{0, 87, 0, 32};
        rx_tbl = '{0, 0, 87, 32};
        reg_min   = PER_W'(MIN_PERIOD_US << FRAC_W);
        reg_max   = PER_W'(MAX_PERIOD_US << FRAC_W);
        reg_accel = rounded_step(ACCEL_STEP_MILLI);
        reg_decel = rounded_step(DECEL_STEP_MILLI);
        m_phase   = PH_IDLE;
        m_period  = '0;
        m_count   = '0;
        m_level   = 1'b0;

        rst_n              = 1'b0;
        tick_bus.valid     = 1'b0;
        tick_bus.start_req = 1'b0;
        tick_bus.limit_a   = 1'b0;
        tick_bus.limit_b   = 1'b0;
        pulse_bus.ready    = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset register values: idle ticks, a start, starts while busy
        queue_tick(1'b0, 2'b00);
        queue_tick(1'b0, 2'b11);
        queue_tick(1'b1, 2'b01);
        queue_tick(1'b1, 2'b10);
        queue_tick(1'b1, 2'b11);
        queue_tick(1'b0, 2'b00);
        // cut the long ramp short: live min/max pinned to the start period
        program_regs(24'h260000, 24'h260000, rounded_step(ACCEL_STEP_MILLI),
                     rounded_step(DECEL_STEP_MILLI));
        finish_move();

        // zero-length halves, accel saturating at zero, unused register indexes
        settle();
        repeat (4) @(negedge clk);
        write_reg(REG_UNUSED_LO, '1);
        write_reg(REG_UNUSED_HI, '1);
        program_regs(24'h000000, 24'h008000, 16'hFFFF, 16'hFFFF);
        queue_tick(1'b1, 2'b00);
        repeat (3) queue_tick(1'b0, 2'b00);
        queue_tick(1'b0, 2'b01);
        queue_tick(1'b0, 2'b10);
        finish_move();

        // longest halves, decel saturating at the all-ones period
        program_regs(24'h020000, 24'h000000, 16'hFFFF, 16'hFFFF);
        queue_tick(1'b1, 2'b00);
        // raised mid-cruise: decel starts from the new min_period
        program_regs(24'hFFF000, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        finish_move();

        // cruise only: min above max, then min equal to max
        program_regs(24'h030000, 24'h000000, 16'h0001, 16'h0001);
        queue_tick(1'b1, 2'b11);
        finish_move();
        program_regs(24'h018000, 24'h018000, 16'h0001, 16'h0001);
        queue_tick(1'b1, 2'b00);
        finish_move();

        // smallest steps
        program_regs(24'h010000, 24'h010004, 16'h0001, 16'h0001);
        queue_tick(1'b1, 2'b00);
        queue_tick(1'b0, 2'b00);
        finish_move();

        for (k = 0; k < 8; k++) begin
            lo  = PER_W'($urandom_range(0, 3 * 65536 - 1));
            sel = $urandom_range(0, 7);
            if (sel == 0) begin
                hi = PER_W'($urandom_range(0, lo));
                up = STEP_W'($urandom_range(1, 65535));
                dn = STEP_W'($urandom_range(1, 65535));
            end else if (sel == 1) begin
                hi = lo + PER_W'($urandom_range(1, 64));
                up = STEP_W'($urandom_range(1, 16));
                dn = STEP_W'($urandom_range(1, 16));
            end else begin
                hi = lo + PER_W'($urandom_range(1, 3 * 65536));
                up = STEP_W'($urandom_range(16384, 65535));
                dn = STEP_W'($urandom_range(16384, 65535));
            end
            program_regs(lo, hi, up, dn);
            tx_idle_pct  = tx_tbl[k % 4];
            rx_stall_pct = rx_tbl[k % 4];
            if (k == 0)
                rx_hold_left <= HOLD_OFF_CYCLES;
            fill_moves(50);
            if (k == 1)
                settle();
            fill_moves(50);
            finish_move();
        end

        settle();
        repeat (8) @(posedge clk);
        $display("covered %0d tick requests over %0d register settings and four pacing modes",
                 ticks_sent, configs_used);
        $display("checked %0d output requests, %0d moves ran to completion",
                 results_seen, moves_done);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #(50_000_000);
        $display("timeout: %0d requests still predicted", awaited_outputs.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
rtl/srpg_pkg.sv
rtl/srpg_if.sv
rtl/srpg_motion.sv
rtl/stepper_ramp_pulse_generator_core.sv
verif/tb_stepper_ramp_pulse_generator_core.sv
